/* design/dsw_pkg.sv */
// Shared types and constants for the debounced stopwatch.
// Holds button debounce state, register indexes and status codes.
// No dependencies.
`timescale 1ns / 1ps

package dsw_pkg;

    localparam int unsigned TICK_W   = 8;
    localparam int unsigned MS_W     = 10;
    localparam int unsigned SEC_W    = 6;
    localparam int unsigned MIN_W    = 6;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned CFG_DATA_W = 8;

    localparam logic [MS_W-1:0]   MS_LAST  = 10'd999;
    localparam logic [SEC_W-1:0]  SEC_LAST = 6'd59;
    localparam logic [MIN_W-1:0]  MIN_LAST = 6'd59;
    localparam logic [TICK_W-1:0] TICK_MAX = 8'd255;

    localparam logic [TICK_W-1:0] DEBOUNCE_RESET = 8'd50;
    localparam logic [TICK_W-1:0] REFRESH_RESET  = 8'd50;

    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_REFRESH  = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_STOP  = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_RUN   = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_PAUSE = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_CLEAR = 2'd3;

    typedef struct packed {
        logic              prev_raw;
        logic              stable;
        logic [TICK_W-1:0] hold;
    } btn_state_t;

    localparam btn_state_t BTN_RESET = '{prev_raw: 1'b1, stable: 1'b1, hold: '0};

endpackage

/* design/dsw_debounce.sv */
// Next-state logic for one active-low button debouncer.
// Depends on dsw_pkg for btn_state_t.
`timescale 1ns / 1ps

module dsw_debounce (
    input  logic                      raw,
    input  logic [dsw_pkg::TICK_W-1:0] debounce_ticks,
    input  dsw_pkg::btn_state_t       cur,
    output dsw_pkg::btn_state_t       nxt,
    output logic                      press
);
    import dsw_pkg::*;

    logic [TICK_W-1:0] hold_next;
    logic              take;

    always_comb
    begin
        if (raw != cur.prev_raw)
        begin
            hold_next = '0;
        end
        else if (cur.hold != TICK_MAX)
        begin
            hold_next = cur.hold + 1'b1;
        end
        else
        begin
            hold_next = cur.hold;
        end
    end

    assign take         = (hold_next >= debounce_ticks) && (raw != cur.stable);
    assign press        = take && !raw;
    assign nxt.prev_raw = raw;
    assign nxt.stable   = take ? raw : cur.stable;
    assign nxt.hold     = hold_next;

endmodule

/* design/dsw_core.sv */
// Stopwatch state, config registers and result register.
// One tick updates all stopwatch state and loads the result register.
// Depends on dsw_pkg and dsw_debounce.
`timescale 1ns / 1ps

module dsw_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [dsw_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [dsw_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                          step_en,
    input  logic                          start_level,
    input  logic                          clear_level,
    input  logic                          out_ready,
    output logic                          out_valid,
    output logic [dsw_pkg::MIN_W-1:0]     shown_minutes,
    output logic [dsw_pkg::SEC_W-1:0]     shown_seconds,
    output logic [dsw_pkg::MS_W-1:0]      shown_millis,
    output logic                          is_running,
    output logic [dsw_pkg::STATUS_W-1:0]  status_code
);
    import dsw_pkg::*;

    logic [TICK_W-1:0]   debounce_reg;
    logic [TICK_W-1:0]   refresh_reg;
    logic                running_reg, running_next;
    btn_state_t          start_reg, start_next;
    btn_state_t          clear_reg, clear_next;
    logic                start_press, clear_press;
    logic [MS_W-1:0]     el_ms_reg, el_ms_next, adv_ms;
    logic [SEC_W-1:0]    el_sec_reg, el_sec_next, adv_sec;
    logic [MIN_W-1:0]    el_min_reg, el_min_next, adv_min;
    logic [MS_W-1:0]     disp_ms_reg, disp_ms_next;
    logic [SEC_W-1:0]    disp_sec_reg, disp_sec_next;
    logic [MIN_W-1:0]    disp_min_reg, disp_min_next;
    logic [TICK_W-1:0]   refresh_reg_cnt, refresh_cnt_next, refresh_inc;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic                out_valid_reg;
    logic [MIN_W-1:0]    out_min_reg;
    logic [SEC_W-1:0]    out_sec_reg;
    logic [MS_W-1:0]     out_ms_reg;
    logic                out_run_reg;
    logic [STATUS_W-1:0] out_status_reg;

    dsw_debounce u_start (
        .raw            (start_level),
        .debounce_ticks (debounce_reg),
        .cur            (start_reg),
        .nxt            (start_next),
        .press          (start_press)
    );

    dsw_debounce u_clear (
        .raw            (clear_level),
        .debounce_ticks (debounce_reg),
        .cur            (clear_reg),
        .nxt            (clear_next),
        .press          (clear_press)
    );

    // advance elapsed time by one ms with carries
    always_comb
    begin
        adv_ms  = el_ms_reg;
        adv_sec = el_sec_reg;
        adv_min = el_min_reg;
        if (el_ms_reg >= MS_LAST)
        begin
            adv_ms = '0;
            if (el_sec_reg >= SEC_LAST)
            begin
                adv_sec = '0;
                adv_min = (el_min_reg >= MIN_LAST) ? '0 : el_min_reg + 1'b1;
            end
            else
            begin
                adv_sec = el_sec_reg + 1'b1;
            end
        end
        else
        begin
            adv_ms = el_ms_reg + 1'b1;
        end
    end

    assign refresh_inc = (refresh_reg_cnt != TICK_MAX) ? refresh_reg_cnt + 1'b1
                                                       : refresh_reg_cnt;

    always_comb
    begin
        el_ms_next    = running_reg ? adv_ms  : el_ms_reg;
        el_sec_next   = running_reg ? adv_sec : el_sec_reg;
        el_min_next   = running_reg ? adv_min : el_min_reg;
        disp_ms_next  = disp_ms_reg;
        disp_sec_next = disp_sec_reg;
        disp_min_next = disp_min_reg;
        running_next  = running_reg;
        status_next   = status_reg;

        if (start_press)
        begin
            running_next = !running_reg;
            status_next  = running_reg ? STATUS_PAUSE : STATUS_RUN;
        end

        if (clear_press && !running_next)
        begin
            el_ms_next    = '0;
            el_sec_next   = '0;
            el_min_next   = '0;
            disp_ms_next  = '0;
            disp_sec_next = '0;
            disp_min_next = '0;
            status_next   = STATUS_CLEAR;
        end

        refresh_cnt_next = refresh_inc;
        if (refresh_inc >= refresh_reg)
        begin
            refresh_cnt_next = '0;
            if (running_next)
            begin
                disp_ms_next  = el_ms_next;
                disp_sec_next = el_sec_next;
                disp_min_next = el_min_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg <= DEBOUNCE_RESET;
            refresh_reg  <= REFRESH_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_DEBOUNCE: debounce_reg <= cfg_data;
                REG_REFRESH:  refresh_reg  <= cfg_data;
                default:      ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg     <= 1'b0;
            start_reg       <= BTN_RESET;
            clear_reg       <= BTN_RESET;
            el_ms_reg       <= '0;
            el_sec_reg      <= '0;
            el_min_reg      <= '0;
            disp_ms_reg     <= '0;
            disp_sec_reg    <= '0;
            disp_min_reg    <= '0;
            refresh_reg_cnt <= '0;
            status_reg      <= STATUS_STOP;
        end
        else if (step_en)
        begin
            running_reg     <= running_next;
            start_reg       <= start_next;
            clear_reg       <= clear_next;
            el_ms_reg       <= el_ms_next;
            el_sec_reg      <= el_sec_next;
            el_min_reg      <= el_min_next;
            disp_ms_reg     <= disp_ms_next;
            disp_sec_reg    <= disp_sec_next;
            disp_min_reg    <= disp_min_next;
            refresh_reg_cnt <= refresh_cnt_next;
            status_reg      <= status_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (step_en)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step_en)
        begin
            out_min_reg    <= disp_min_next;
            out_sec_reg    <= disp_sec_next;
            out_ms_reg     <= disp_ms_next;
            out_run_reg    <= running_next;
            out_status_reg <= status_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign shown_minutes = out_min_reg;
    assign shown_seconds = out_sec_reg;
    assign shown_millis  = out_ms_reg;
    assign is_running    = out_run_reg;
    assign status_code   = out_status_reg;

endmodule

/* design/debounced_stopwatch_unit.sv */
// Top level of the debounced stopwatch: input register and handshake.
// Depends on dsw_pkg and dsw_core.
//
//   channel  | handshake           | payload
//   ---------+---------------------+-------------------------------------------
//   in       | in_valid / in_ready | start_button_level, clear_button_level
//   out      | out_valid/out_ready | shown_minutes/seconds/millis, is_running,
//            |                     | status_code
//   cfg      | cfg_we              | cfg_index, cfg_data
//
// A beat lands in the input register, then, once the output is free or being taken,
// updates the state and loads the result register, one beat per cycle while the
// output is not stalled.
// The input register takes a new beat while a result waits to be taken, if it is empty.
// Reset returns both config registers to 50 and the watch to stopped, 00:00:000.
// A stalled output holds the result; one more beat waits in the input register.
`timescale 1ns / 1ps

module debounced_stopwatch_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [dsw_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [dsw_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          start_button_level,
    input  logic                          clear_button_level,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [dsw_pkg::MIN_W-1:0]     shown_minutes,
    output logic [dsw_pkg::SEC_W-1:0]     shown_seconds,
    output logic [dsw_pkg::MS_W-1:0]      shown_millis,
    output logic                          is_running,
    output logic [dsw_pkg::STATUS_W-1:0]  status_code
);
    import dsw_pkg::*;

    logic in_valid_reg;
    logic start_lvl_reg;
    logic clear_lvl_reg;
    logic step_en;

    assign step_en  = in_valid_reg && (!out_valid || out_ready);
    assign in_ready = !in_valid_reg || step_en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            start_lvl_reg <= start_button_level;
            clear_lvl_reg <= clear_button_level;
        end
    end

    dsw_core u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .step_en       (step_en),
        .start_level   (start_lvl_reg),
        .clear_level   (clear_lvl_reg),
        .out_ready     (out_ready),
        .out_valid     (out_valid),
        .shown_minutes (shown_minutes),
        .shown_seconds (shown_seconds),
        .shown_millis  (shown_millis),
        .is_running    (is_running),
        .status_code   (status_code)
    );

endmodule

/* design/dsw_checker.sv */
// Port-level checks for debounced_stopwatch_unit, attached with bind.
// Depends on dsw_pkg for status codes and field limits.
`timescale 1ns / 1ps

module dsw_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic [dsw_pkg::MIN_W-1:0]     shown_minutes,
    input logic [dsw_pkg::SEC_W-1:0]     shown_seconds,
    input logic [dsw_pkg::MS_W-1:0]      shown_millis,
    input logic                          is_running,
    input logic [dsw_pkg::STATUS_W-1:0]  status_code
);
    import dsw_pkg::*;

    // hold a stalled result beat
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(shown_millis)
            && $stable(shown_seconds) && $stable(shown_minutes) && $stable(status_code))
    else $error("stalled result beat changed");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (is_running == (status_code == STATUS_RUN)))
    else $error("run flag and status disagree");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> shown_millis <= MS_LAST && shown_seconds <= SEC_LAST
            && shown_minutes <= MIN_LAST)
    else $error("displayed time out of range");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status_code == STATUS_CLEAR || status_code == STATUS_STOP)
            |-> shown_millis == '0 && shown_seconds == '0 && shown_minutes == '0)
    else $error("display not zero after clear or power-up");

endmodule

bind debounced_stopwatch_unit dsw_checker u_dsw_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .shown_minutes (shown_minutes),
    .shown_seconds (shown_seconds),
    .shown_millis  (shown_millis),
    .is_running    (is_running),
    .status_code   (status_code)
);

/* tb/tb_debounced_stopwatch_unit.sv */
// Self-checking testbench for debounced_stopwatch_unit: button gestures, glitches and
// long runs under random idling, checked tick by tick by a stopwatch predictor.
// Depends on dsw_pkg and the debounced_stopwatch_unit RTL.
`timescale 1ns / 1ps

module tb_debounced_stopwatch_unit;

    import dsw_pkg::*;

    typedef struct packed {
        logic [MIN_W-1:0]    min;
        logic [SEC_W-1:0]    sec;
        logic [MS_W-1:0]     ms;
        logic                run;
        logic [STATUS_W-1:0] status;
    } reading_t;

    class stopwatch_scoreboard;
        logic [TICK_W-1:0]   debounce_ticks;
        logic [TICK_W-1:0]   refresh_ticks;
        logic                running;
        btn_state_t          start_btn;
        btn_state_t          clear_btn;
        logic [MS_W-1:0]     el_ms;
        logic [SEC_W-1:0]    el_sec;
        logic [MIN_W-1:0]    el_min;
        logic [MS_W-1:0]     disp_ms;
        logic [SEC_W-1:0]    disp_sec;
        logic [MIN_W-1:0]    disp_min;
        logic [TICK_W-1:0]   refresh_cnt;
        logic [STATUS_W-1:0] status;
        reading_t            due_readings[$];
        int                  faults;

        function new();
            debounce_ticks = DEBOUNCE_RESET;
            refresh_ticks  = REFRESH_RESET;
            running        = 1'b0;
            start_btn      = BTN_RESET;
            clear_btn      = BTN_RESET;
            el_ms          = '0;
            el_sec         = '0;
            el_min         = '0;
            disp_ms        = '0;
            disp_sec       = '0;
            disp_min       = '0;
            refresh_cnt    = '0;
            status         = STATUS_STOP;
            faults         = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                REG_DEBOUNCE: debounce_ticks = val;
                REG_REFRESH:  refresh_ticks  = val;
                default:      ;
            endcase
        endfunction

        function int pending();
            return due_readings.size();
        endfunction

        function void flag(string msg);
            faults++;
            if (faults <= 10)
                $display("MISMATCH: %s", msg);
        endfunction

        function bit settle_button(inout btn_state_t b, input logic raw);
            bit pressed;
            pressed = 1'b0;
            if (raw != b.prev_raw)
                b.hold = '0;
            else if (b.hold != TICK_MAX)
                b.hold = b.hold + 1'b1;
            if (b.hold >= debounce_ticks && raw != b.stable)
            begin
                b.stable = raw;
                pressed  = (raw == 1'b0);
            end
            b.prev_raw = raw;
            return pressed;
        endfunction

        function void note_tick(logic start_lvl, logic clear_lvl);
            reading_t r;
            if (running)
            begin
                if (el_ms >= MS_LAST)
                begin
                    el_ms = '0;
                    if (el_sec >= SEC_LAST)
                    begin
                        el_sec = '0;
                        el_min = (el_min >= MIN_LAST) ? '0 : el_min + 1'b1;
                    end
                    else
                        el_sec = el_sec + 1'b1;
                end
                else
                    el_ms = el_ms + 1'b1;
            end
            if (settle_button(start_btn, start_lvl))
            begin
                running = !running;
                status  = running ? STATUS_RUN : STATUS_PAUSE;
            end
            if (settle_button(clear_btn, clear_lvl) && !running)
            begin
                el_ms    = '0;
                el_sec   = '0;
                el_min   = '0;
                disp_ms  = '0;
                disp_sec = '0;
                disp_min = '0;
                status   = STATUS_CLEAR;
            end
            if (refresh_cnt != TICK_MAX)
                refresh_cnt = refresh_cnt + 1'b1;
            if (refresh_cnt >= refresh_ticks)
            begin
                refresh_cnt = '0;
                if (running)
                begin
                    disp_ms  = el_ms;
                    disp_sec = el_sec;
                    disp_min = el_min;
                end
            end
            r = '{min: disp_min, sec: disp_sec, ms: disp_ms, run: running, status: status};
            due_readings.push_back(r);
        endfunction

        function void check_reading(reading_t got);
            reading_t want;
            if (due_readings.size() == 0)
            begin
                flag($sformatf("unexpected beat %0d:%0d.%0d run=%0d status=%0d",
                               got.min, got.sec, got.ms, got.run, got.status));
                return;
            end
            want = due_readings.pop_front();
            if (got.min !== want.min || got.sec !== want.sec || got.ms !== want.ms ||
                got.run !== want.run || got.status !== want.status)
                flag($sformatf({"expected %0d:%0d.%0d run=%0d status=%0d, ",
                                "got %0d:%0d.%0d run=%0d status=%0d"},
                               want.min, want.sec, want.ms, want.run, want.status,
                               got.min, got.sec, got.ms, got.run, got.status));
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_ready;
    logic                  start_button_level;
    logic                  clear_button_level;
    logic                  out_valid;
    logic                  out_ready;
    logic [MIN_W-1:0]      shown_minutes;
    logic [SEC_W-1:0]      shown_seconds;
    logic [MS_W-1:0]       shown_millis;
    logic                  is_running;
    logic [STATUS_W-1:0]   status_code;

    bit                    pace_idle = 1'b1;
    stopwatch_scoreboard   board = new();

    debounced_stopwatch_unit dut (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg_we             (cfg_we),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .in_valid           (in_valid),
        .in_ready           (in_ready),
        .start_button_level (start_button_level),
        .clear_button_level (clear_button_level),
        .out_valid          (out_valid),
        .out_ready          (out_ready),
        .shown_minutes      (shown_minutes),
        .shown_seconds      (shown_seconds),
        .shown_millis       (shown_millis),
        .is_running         (is_running),
        .status_code        (status_code)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    task automatic send_tick(input logic start_lvl, input logic clear_lvl);
        int gap;
        gap = pace_idle ? $urandom_range(0, 15) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid           <= 1'b1;
        start_button_level <= start_lvl;
        clear_button_level <= clear_lvl;
        do
            @(posedge clk);
        while (!in_ready);
        board.note_tick(start_lvl, clear_lvl);
    endtask

    task automatic hold_level(input logic start_lvl, input logic clear_lvl, input int n);
        repeat (n) send_tick(start_lvl, clear_lvl);
    endtask

    task automatic settle_idle();
        in_valid <= 1'b0;
        while (board.pending() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic program_timing(input logic [TICK_W-1:0] deb, input logic [TICK_W-1:0] rf);
        cfg_we    <= 1'b1;
        cfg_index <= REG_DEBOUNCE;
        cfg_data  <= deb;
        @(posedge clk);
        board.write_reg(REG_DEBOUNCE, deb);
        cfg_index <= REG_REFRESH;
        cfg_data  <= rf;
        @(posedge clk);
        board.write_reg(REG_REFRESH, rf);
        cfg_we <= 1'b0;
    endtask

    // receive side: random stall before each beat
    initial
    begin
        int stall;
        out_ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall = pace_idle ? $urandom_range(0, 15) : 0;
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (!out_valid);
            board.check_reading('{shown_minutes, shown_seconds, shown_millis,
                                  is_running, status_code});
        end
    end

    initial
    begin
        logic [TICK_W-1:0] deb;
        logic [TICK_W-1:0] rf;
        int                sent;
        int                span;
        int                pick;
        logic              s_lvl;
        logic              c_lvl;

        rst_n              <= 1'b0;
        cfg_we             <= 1'b0;
        cfg_index          <= '0;
        cfg_data           <= '0;
        in_valid           <= 1'b0;
        start_button_level <= 1'b1;
        clear_button_level <= 1'b1;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // power-up defaults: short glitches never get through
        hold_level(1'b1, 1'b1, 3);
        hold_level(1'b0, 1'b1, 2);
        hold_level(1'b1, 1'b0, 2);
        send_tick(1'b1, 1'b1);

        // zero debounce and zero refresh
        settle_idle();
        program_timing(8'd0, 8'd0);
        hold_level(1'b0, 1'b1, 2);
        send_tick(1'b1, 1'b1);
        send_tick(1'b1, 1'b0);
        hold_level(1'b1, 1'b1, 2);
        send_tick(1'b0, 1'b1);
        send_tick(1'b1, 1'b1);
        send_tick(1'b1, 1'b0);
        send_tick(1'b0, 1'b0);
        send_tick(1'b1, 1'b1);
        send_tick(1'b0, 1'b0);
        send_tick(1'b1, 1'b1);

        // longest debounce and refresh; hold count saturates
        settle_idle();
        program_timing(8'd255, 8'd255);
        hold_level(1'b0, 1'b1, 258);
        hold_level(1'b1, 1'b1, 12);

        // steady run without idling
        settle_idle();
        pace_idle = 1'b0;
        program_timing(8'd3, 8'($urandom_range(1, 255)));
        hold_level(1'b0, 1'b1, 5);
        hold_level(1'b1, 1'b0, 5);
        hold_level(1'b0, 1'b1, 5);
        hold_level(1'b1, 1'b1, 100);
        hold_level(1'b0, 1'b1, 5);
        hold_level(1'b1, 1'b1, 3);

        // random gestures, glitches and noise under several timings
        for (int seg = 0; seg < 6; seg++)
        begin
            settle_idle();
            pace_idle = (seg != 2);
            pick = $urandom_range(0, 7);
            deb  = (seg == 0) ? 8'd0 : (pick == 0) ? 8'($urandom_range(8, 16))
                                                  : 8'($urandom_range(1, 5));
            pick = $urandom_range(0, 3);
            rf   = (pick == 0) ? 8'd1 : (pick == 1) ? 8'd255 : 8'($urandom_range(0, 80));
            program_timing(deb, rf);
            sent = 0;
            while (sent < 18)
            begin
                pick = $urandom_range(0, 19);
                if (pick == 0)
                    settle_idle();
                else if (pick < 4)
                begin
                    span = $urandom_range(1, 4);
                    repeat (span) send_tick(1'($urandom), 1'($urandom));
                    sent += span;
                end
                else if (pick < 6)
                begin
                    span = $urandom_range(5, 30);
                    hold_level(1'b1, 1'b1, span);
                    sent += span;
                end
                else
                begin
                    s_lvl = (pick % 3 == 1);
                    c_lvl = (pick % 3 == 2);
                    if (pick % 3 == 0)
                    begin
                        s_lvl = 1'b0;
                        c_lvl = 1'b0;
                    end
                    else
                    begin
                        s_lvl = !s_lvl;
                        c_lvl = !c_lvl;
                    end
                    if (deb > 0 && $urandom_range(0, 3) == 0)
                        span = $urandom_range(1, deb);
                    else
                        span = deb + 1 + $urandom_range(0, 2);
                    hold_level(s_lvl, c_lvl, span);
                    sent += span;
                    span = deb + 1 + $urandom_range(0, 3);
                    hold_level(1'b1, 1'b1, span);
                    sent += span;
                end
            end
        end

        settle_idle();
        repeat (10) @(posedge clk);
        if (board.faults == 0 && board.pending() == 0)
            $display("debounced_stopwatch_unit verification clean");
        else
            $display("debounced_stopwatch_unit verification failed");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("debounced_stopwatch_unit verification failed");
        $finish;
    end

endmodule

/* files.f */
design/dsw_pkg.sv
design/dsw_debounce.sv
design/dsw_core.sv
design/debounced_stopwatch_unit.sv
design/dsw_checker.sv
tb/tb_debounced_stopwatch_unit.sv
